[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the tpc_ctrl sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[src/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths and control/config types of the touch point calibrator.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int RAW_W     = 12;              // raw ADC sample width
  localparam int RES_W     = 10;              // resolution / held point width
  localparam int PROD_W    = RAW_W + RES_W;   // offset * resolution
  localparam int OUT_W     = 9;               // pixel coordinate port width
  localparam int DIV_STEPS = PROD_W;          // one quotient bit per cycle
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [RAW_W-1:0] x_raw_min;
    logic [RAW_W-1:0] x_raw_max;
    logic [RAW_W-1:0] y_raw_min;
    logic [RAW_W-1:0] y_raw_max;
    logic             invert_x;
    logic             invert_y;
    logic             swap_axes;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture raw sample, form offsets
    logic mul;       // scale offsets by resolution, clear remainders
    logic div_step;  // one restoring division step on both axes
    logic fin;       // saturate, mirror and update the held point
    logic out_load;  // move held point into the output register
    logic pressed;   // pressed flag for the result being loaded
  } cmd_t;

endpackage

[src/touch_point_calibrate_unit.sv]
// ----------------------------------------------------------------------------
// touch_point_calibrate_unit
// Linear calibration of raw resistive touch samples into pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one transfer per controller poll carrying the
//   touched and sample-present flags plus the newest raw 12-bit X/Y pair.
//   Result channel (out_*): exactly one transfer per input transfer, in order.
//   A poll with both flags set yields the newly calibrated point with
//   out_pressed high; any other poll yields the held point with it low.
//   Steps: a pressed poll runs the scale step, 22 restoring division steps,
//   the clamp step and the output load; a released poll goes straight to
//   the output load. The 22-step division loop runs on both axes at once,
//   and a new poll is taken only once the current one has been loaded.
//   in_stall is high while an item is in work; the output register lets the
//   block take a new item while the previous result is still waiting.
//   If out_stall holds the output register full, the finished item waits in
//   place and no further input is taken. Reset: calibration registers return
//   to their defaults, held point is 0, no result is pending. The user must
//   write registers over the APB port only while idle; the block won't check.
// ----------------------------------------------------------------------------
module touch_point_calibrate_unit import tpc_pkg::*; #(
  parameter int H_RES = 480,
  parameter int V_RES = 320
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_touched,
  input  logic             in_sample_present,
  input  logic [RAW_W-1:0] in_raw_x,
  input  logic [RAW_W-1:0] in_raw_y,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] out_point_x,
  output logic [OUT_W-1:0] out_point_y,
  output logic             out_pressed,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_X_MIN  = 3'd0;
  localparam logic [2:0] REG_X_MAX  = 3'd1;
  localparam logic [2:0] REG_Y_MIN  = 3'd2;
  localparam logic [2:0] REG_Y_MAX  = 3'd3;
  localparam logic [2:0] REG_INV_X  = 3'd4;
  localparam logic [2:0] REG_INV_Y  = 3'd5;
  localparam logic [2:0] REG_SWAP   = 3'd6;

  cfg_t       cfg_r;
  cmd_t       cmd;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register file: take the write on the access cycle, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_raw_min <= RAW_W'(1000);
      cfg_r.x_raw_max <= RAW_W'(3200);
      cfg_r.y_raw_min <= RAW_W'(1000);
      cfg_r.y_raw_max <= RAW_W'(2000);
      cfg_r.invert_x  <= 1'b1;
      cfg_r.invert_y  <= 1'b1;
      cfg_r.swap_axes <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_MIN: cfg_r.x_raw_min <= pwdata[RAW_W-1:0];
        REG_X_MAX: cfg_r.x_raw_max <= pwdata[RAW_W-1:0];
        REG_Y_MIN: cfg_r.y_raw_min <= pwdata[RAW_W-1:0];
        REG_Y_MAX: cfg_r.y_raw_max <= pwdata[RAW_W-1:0];
        REG_INV_X: cfg_r.invert_x  <= pwdata[0];
        REG_INV_Y: cfg_r.invert_y  <= pwdata[0];
        REG_SWAP:  cfg_r.swap_axes <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register, zero-extended.
  always_comb begin
    case (reg_idx)
      REG_X_MIN: prdata = 32'(cfg_r.x_raw_min);
      REG_X_MAX: prdata = 32'(cfg_r.x_raw_max);
      REG_Y_MIN: prdata = 32'(cfg_r.y_raw_min);
      REG_Y_MAX: prdata = 32'(cfg_r.y_raw_max);
      REG_INV_X: prdata = 32'(cfg_r.invert_x);
      REG_INV_Y: prdata = 32'(cfg_r.invert_y);
      REG_SWAP:  prdata = 32'(cfg_r.swap_axes);
      default:   prdata = '0;
    endcase
  end

  // Sequencer: handshakes and step count.
  tpc_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_touched        (in_touched),
    .in_sample_present (in_sample_present),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .cmd               (cmd)
  );

  // Arithmetic for both axes, held point and result payload.
  tpc_datapath #(
    .H_RES (H_RES),
    .V_RES (V_RES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_r),
    .in_raw_x    (in_raw_x),
    .in_raw_y    (in_raw_y),
    .out_point_x (out_point_x),
    .out_point_y (out_point_y),
    .out_pressed (out_pressed)
  );

endmodule

[src/tpc_ctrl.sv]
// ----------------------------------------------------------------------------
// tpc_ctrl
// Sequencer: input handshake, division step count and output register valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpc_ctrl import tpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_touched,
  input  logic in_sample_present,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pressed_r, pressed_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, press, out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign press     = in_touched & in_sample_present;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pressed_nxt = pressed_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pressed_nxt = press;
          state_nxt   = press ? ST_MUL : ST_PUT;
        end
      end
      ST_MUL: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load     = accept & press;
    cmd.mul      = (state_r == ST_MUL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.fin      = (state_r == ST_FIN);
    cmd.out_load = (state_r == ST_PUT) & out_free;
    cmd.pressed  = pressed_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pressed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pressed_r   <= pressed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_CLK(a_fin_after_div, clk, rst_n, (state_r == ST_FIN) |-> ($past(state_r) == ST_DIV))
  `ASSERT_CLK(a_accept_leaves_idle, clk, rst_n, accept |=> (state_r != ST_IDLE))
  `ASSERT_CLK(a_out_from_put, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == ST_PUT))

endmodule

[src/tpc_datapath.sv]
// ----------------------------------------------------------------------------
// tpc_datapath
// Offset, scale, restoring divide, clamp and mirror for both axes; held point
// and output register.
// ----------------------------------------------------------------------------
module tpc_datapath import tpc_pkg::*; #(
  parameter int H_RES = 480,
  parameter int V_RES = 320
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  cfg_t             cfg,
  input  logic [RAW_W-1:0] in_raw_x,
  input  logic [RAW_W-1:0] in_raw_y,
  output logic [OUT_W-1:0] out_point_x,
  output logic [OUT_W-1:0] out_point_y,
  output logic             out_pressed
);

  localparam logic [RES_W-1:0] HRES_V = RES_W'(H_RES);
  localparam logic [RES_W-1:0] VRES_V = RES_W'(V_RES);

  logic [RAW_W-1:0]  rx, ry;
  logic [RAW_W-1:0]  off_x_r, off_y_r;
  logic [PROD_W-1:0] num_x_r, num_y_r;   // dividend bits out, quotient bits in
  logic [RAW_W-1:0]  rem_x_r, rem_y_r;
  logic [RAW_W-1:0]  div_x, div_y;
  logic              ok_x, ok_y;
  logic [RAW_W:0]    trial_x, trial_y;
  logic              q_x, q_y;
  logic [RES_W-1:0]  val_x, val_y;
  logic [RES_W-1:0]  held_x_r, held_y_r;
  logic [OUT_W-1:0]  out_x_r, out_y_r;
  logic              out_pressed_r;

  assign rx = cfg.swap_axes ? in_raw_y : in_raw_x;
  assign ry = cfg.swap_axes ? in_raw_x : in_raw_y;

  assign ok_x  = cfg.x_raw_max > cfg.x_raw_min;
  assign ok_y  = cfg.y_raw_max > cfg.y_raw_min;
  assign div_x = cfg.x_raw_max - cfg.x_raw_min;
  assign div_y = cfg.y_raw_max - cfg.y_raw_min;

  assign trial_x = {rem_x_r, num_x_r[PROD_W-1]};
  assign trial_y = {rem_y_r, num_y_r[PROD_W-1]};
  assign q_x     = trial_x >= {1'b0, div_x};
  assign q_y     = trial_y >= {1'b0, div_y};

  // Clamp at the resolution, zero on an empty span, then mirror.
  always_comb begin
    val_x = '0;
    val_y = '0;
    if (ok_x) begin
      val_x = (num_x_r > PROD_W'(HRES_V)) ? HRES_V : num_x_r[RES_W-1:0];
    end
    if (ok_y) begin
      val_y = (num_y_r > PROD_W'(VRES_V)) ? VRES_V : num_y_r[RES_W-1:0];
    end
    if (cfg.invert_x) begin
      val_x = HRES_V - val_x;
    end
    if (cfg.invert_y) begin
      val_y = VRES_V - val_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_x_r <= (rx > cfg.x_raw_min) ? (rx - cfg.x_raw_min) : '0;
      off_y_r <= (ry > cfg.y_raw_min) ? (ry - cfg.y_raw_min) : '0;
    end
    if (cmd.mul) begin
      num_x_r <= PROD_W'(off_x_r) * PROD_W'(HRES_V);
      num_y_r <= PROD_W'(off_y_r) * PROD_W'(VRES_V);
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (cmd.div_step) begin
      rem_x_r <= q_x ? RAW_W'(trial_x - {1'b0, div_x}) : trial_x[RAW_W-1:0];
      rem_y_r <= q_y ? RAW_W'(trial_y - {1'b0, div_y}) : trial_y[RAW_W-1:0];
      num_x_r <= {num_x_r[PROD_W-2:0], q_x};
      num_y_r <= {num_y_r[PROD_W-2:0], q_y};
    end
    if (cmd.out_load) begin
      out_x_r       <= held_x_r[OUT_W-1:0];
      out_y_r       <= held_y_r[OUT_W-1:0];
      out_pressed_r <= cmd.pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= '0;
      held_y_r <= '0;
    end else if (cmd.fin) begin
      held_x_r <= val_x;
      held_y_r <= val_y;
    end
  end

  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_pressed = out_pressed_r;

endmodule
